@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the TCP reply header generator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on the rising clock, off during reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ rtl/tcprg_pkg.sv @@
// Types, constants and the checksum fold for the TCP reply header generator.
// No dependencies; the cfg, state, csum and top modules refer to it by scoped names.
`default_nettype none

package tcprg_pkg;

    localparam int unsigned SUM_W = 20;

    typedef logic [SUM_W-1:0] t_sum;

    localparam logic [5:0] FLAG_FIN  = 6'h01;
    localparam logic [5:0] FLAG_SYN  = 6'h02;
    localparam logic [5:0] FLAG_PSH  = 6'h08;
    localparam logic [5:0] FLAG_ACK  = 6'h10;
    localparam logic [5:0] FLAG_SYN_ACK = FLAG_SYN | FLAG_ACK;
    localparam logic [5:0] FLAG_PSH_ACK = FLAG_PSH | FLAG_ACK;
    localparam logic [5:0] FLAG_FIN_ACK = FLAG_FIN | FLAG_ACK;

    localparam logic [15:0] IP_VER_IHL_TOS  = 16'h4500;
    localparam logic [15:0] IP_TOTAL_LEN    = 16'd40;
    localparam logic [15:0] IP_TTL_PROTO    = 16'hff06;
    localparam logic [15:0] TCP_PROTO       = 16'd6;
    localparam logic [15:0] TCP_HDR_LEN     = 16'd20;
    localparam logic [15:0] TCP_OFFSET_WORD = 16'h5000;

    localparam logic [31:0] RST_LOCAL_IP    = 32'd0;
    localparam logic [31:0] RST_REMOTE_IP   = 32'h0a000001;
    localparam logic [15:0] RST_LOCAL_PORT  = 16'd0;
    localparam logic [15:0] RST_REMOTE_PORT = 16'd80;
    localparam logic [15:0] RST_WINDOW      = 16'd1400;

    typedef enum logic [2:0] {
        REG_LOCAL_IP    = 3'd0,
        REG_REMOTE_IP   = 3'd1,
        REG_LOCAL_PORT  = 3'd2,
        REG_REMOTE_PORT = 3'd3,
        REG_WINDOW      = 3'd4
    } t_reg_idx;

    typedef enum logic {
        OP_RESPOND = 1'b0,
        OP_OPEN    = 1'b1
    } t_op;

    typedef struct packed {
        logic [31:0] local_ip;
        logic [31:0] remote_ip;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [15:0] window_size;
    } t_cfg;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] ack;
        logic [5:0]  flags;
        logic [15:0] ip_id;
        logic        ok;
    } t_hdr;

    typedef struct packed {
        t_hdr        hdr;
        logic [15:0] ip_checksum;
        logic [15:0] tcp_checksum;
    } t_result;

    // End-around fold of a raw word sum, then invert. A sum that folds to
    // zero stands for all-ones, whose complement is zero.
    function automatic logic [15:0] csum_fold(input t_sum s);
        logic [16:0] r1;
        logic [15:0] r2;
        r1 = 17'(s[15:0]) + 17'(s[SUM_W-1:16]);
        r2 = r1[15:0] + 16'(r1[16]);
        return (r2 == 16'd0) ? 16'd0 : ~r2;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tcprg_cfg.sv @@
// APB register file for the header generator: addresses, ports, window.
// Depends on tcprg_pkg.
`default_nettype none

module tcprg_cfg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output tcprg_pkg::t_cfg         o_cfg
);

    tcprg_pkg::t_cfg r_cfg;
    tcprg_pkg::t_reg_idx w_idx;
    logic w_wr;

    assign pready = 1'b1;
    assign w_idx  = tcprg_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_ip    <= tcprg_pkg::RST_LOCAL_IP;
            r_cfg.remote_ip   <= tcprg_pkg::RST_REMOTE_IP;
            r_cfg.local_port  <= tcprg_pkg::RST_LOCAL_PORT;
            r_cfg.remote_port <= tcprg_pkg::RST_REMOTE_PORT;
            r_cfg.window_size <= tcprg_pkg::RST_WINDOW;
        end else if (w_wr) begin
            unique case (w_idx)
                tcprg_pkg::REG_LOCAL_IP:    r_cfg.local_ip    <= pwdata;
                tcprg_pkg::REG_REMOTE_IP:   r_cfg.remote_ip   <= pwdata;
                tcprg_pkg::REG_LOCAL_PORT:  r_cfg.local_port  <= pwdata[15:0];
                tcprg_pkg::REG_REMOTE_PORT: r_cfg.remote_port <= pwdata[15:0];
                tcprg_pkg::REG_WINDOW:      r_cfg.window_size <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            tcprg_pkg::REG_LOCAL_IP:    prdata = r_cfg.local_ip;
            tcprg_pkg::REG_REMOTE_IP:   prdata = r_cfg.remote_ip;
            tcprg_pkg::REG_LOCAL_PORT:  prdata = {16'd0, r_cfg.local_port};
            tcprg_pkg::REG_REMOTE_PORT: prdata = {16'd0, r_cfg.remote_port};
            tcprg_pkg::REG_WINDOW:      prdata = {16'd0, r_cfg.window_size};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/tcprg_state.sv @@
// Connection state update: sequence, ack, flags and IP id per accepted beat.
// The state registers double as the first pipeline stage. Depends on tcprg_pkg.
`default_nettype none

`include "assert_macros.svh"

module tcprg_state (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_op,
    input  wire logic [5:0]         i_rx_flags,
    input  wire logic [31:0]        i_rx_seq,
    input  wire logic [31:0]        i_rx_ack,
    input  wire logic [10:0]        i_payload_len,
    input  wire logic [31:0]        i_initial_seq,
    input  wire logic               i_take,
    output logic                    o_valid,
    output tcprg_pkg::t_hdr         o_hdr
);

    tcprg_pkg::t_hdr r_hdr;
    logic            r_valid;
    tcprg_pkg::t_hdr n_hdr;
    logic            w_accept;
    logic [31:0]     w_addend;

    assign o_ready  = !r_valid || i_take;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_hdr    = r_hdr;

    always_comb begin
        n_hdr    = r_hdr;
        n_hdr.ok = 1'b1;
        w_addend = 32'd1;
        if (tcprg_pkg::t_op'(i_op) == tcprg_pkg::OP_OPEN) begin
            n_hdr.seq   = i_initial_seq;
            n_hdr.ack   = 32'd0;
            n_hdr.flags = tcprg_pkg::FLAG_SYN;
        end else begin
            unique case (i_rx_flags)
                tcprg_pkg::FLAG_SYN_ACK: begin
                    w_addend    = 32'd1;
                    n_hdr.flags = tcprg_pkg::FLAG_ACK;
                end
                tcprg_pkg::FLAG_ACK: begin
                    w_addend    = 32'd0;
                    n_hdr.flags = tcprg_pkg::FLAG_ACK;
                end
                tcprg_pkg::FLAG_PSH_ACK: begin
                    w_addend    = 32'(i_payload_len);
                    n_hdr.flags = tcprg_pkg::FLAG_ACK;
                end
                tcprg_pkg::FLAG_FIN_ACK: begin
                    w_addend    = 32'd1;
                    n_hdr.flags = tcprg_pkg::FLAG_FIN_ACK;
                end
                default: begin
                    n_hdr.ok = 1'b0;
                end
            endcase
            if (n_hdr.ok) begin
                n_hdr.seq = i_rx_ack;
                n_hdr.ack = i_rx_seq + w_addend;
            end
        end
        if (n_hdr.ok) begin
            n_hdr.ip_id = r_hdr.ip_id + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_hdr.seq   <= 32'd0;
            r_hdr.ack   <= 32'd0;
            r_hdr.flags <= 6'd0;
            r_hdr.ip_id <= 16'd0;
            r_hdr.ok    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
                r_hdr   <= n_hdr;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    `ASSERT_AT(a_resend_holds, i_clk, i_rst_n,
        (w_accept && !n_hdr.ok) |=> (r_hdr.seq == $past(r_hdr.seq)
            && r_hdr.ack == $past(r_hdr.ack) && r_hdr.flags == $past(r_hdr.flags)),
        "unrecognized beat changed the connection state")
    `ASSERT_AT(a_id_step, i_clk, i_rst_n,
        (w_accept && n_hdr.ok) |=> (r_hdr.ip_id == $past(r_hdr.ip_id) + 16'd1),
        "IP id did not advance by one on a recognized beat")
    `ASSERT_AT(a_open_syn, i_clk, i_rst_n,
        (w_accept && i_op) |=> (r_hdr.flags == tcprg_pkg::FLAG_SYN && r_hdr.ack == 32'd0),
        "open beat did not load a SYN header")

endmodule

`default_nettype wire

@@ rtl/tcprg_csum.sv @@
// Checksum stages: raw word sums into a register, then fold and invert into
// the output register. Depends on tcprg_pkg.
`default_nettype none

module tcprg_csum (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_take,
    input  wire tcprg_pkg::t_hdr    i_hdr,
    input  wire tcprg_pkg::t_cfg    i_cfg,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output tcprg_pkg::t_result      o_result
);

    logic                           r_b_valid;
    tcprg_pkg::t_hdr                r_b_hdr;
    tcprg_pkg::t_sum                r_b_ip_sum;
    tcprg_pkg::t_sum                r_b_tcp_sum;
    tcprg_pkg::t_sum                n_b_ip_sum;
    tcprg_pkg::t_sum                n_b_tcp_sum;
    logic                           r_c_valid;
    tcprg_pkg::t_result             r_c_result;
    logic                           w_c_load;

    // Output stage frees up when empty or when its beat is taken.
    assign w_c_load = r_b_valid && (!r_c_valid || i_ready);
    assign o_take   = i_valid && (!r_b_valid || w_c_load);
    assign o_valid  = r_c_valid;
    assign o_result = r_c_result;

    always_comb begin
        n_b_ip_sum = tcprg_pkg::t_sum'(tcprg_pkg::IP_VER_IHL_TOS)
                   + tcprg_pkg::t_sum'(tcprg_pkg::IP_TOTAL_LEN)
                   + tcprg_pkg::t_sum'(i_hdr.ip_id)
                   + tcprg_pkg::t_sum'(tcprg_pkg::IP_TTL_PROTO)
                   + tcprg_pkg::t_sum'(i_cfg.local_ip[31:16])
                   + tcprg_pkg::t_sum'(i_cfg.local_ip[15:0])
                   + tcprg_pkg::t_sum'(i_cfg.remote_ip[31:16])
                   + tcprg_pkg::t_sum'(i_cfg.remote_ip[15:0]);
        n_b_tcp_sum = tcprg_pkg::t_sum'(i_cfg.local_ip[31:16])
                    + tcprg_pkg::t_sum'(i_cfg.local_ip[15:0])
                    + tcprg_pkg::t_sum'(i_cfg.remote_ip[31:16])
                    + tcprg_pkg::t_sum'(i_cfg.remote_ip[15:0])
                    + tcprg_pkg::t_sum'(tcprg_pkg::TCP_PROTO)
                    + tcprg_pkg::t_sum'(tcprg_pkg::TCP_HDR_LEN)
                    + tcprg_pkg::t_sum'(i_cfg.local_port)
                    + tcprg_pkg::t_sum'(i_cfg.remote_port)
                    + tcprg_pkg::t_sum'(i_hdr.seq[31:16])
                    + tcprg_pkg::t_sum'(i_hdr.seq[15:0])
                    + tcprg_pkg::t_sum'(i_hdr.ack[31:16])
                    + tcprg_pkg::t_sum'(i_hdr.ack[15:0])
                    + tcprg_pkg::t_sum'(tcprg_pkg::TCP_OFFSET_WORD | 16'(i_hdr.flags))
                    + tcprg_pkg::t_sum'(i_cfg.window_size);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_b_valid <= 1'b1;
            end else if (w_c_load) begin
                r_b_valid <= 1'b0;
            end
            if (w_c_load) begin
                r_c_valid <= 1'b1;
            end else if (i_ready) begin
                r_c_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_b_hdr     <= i_hdr;
            r_b_ip_sum  <= n_b_ip_sum;
            r_b_tcp_sum <= n_b_tcp_sum;
        end
        if (w_c_load) begin
            r_c_result.hdr          <= r_b_hdr;
            r_c_result.ip_checksum  <= tcprg_pkg::csum_fold(r_b_ip_sum);
            r_c_result.tcp_checksum <= tcprg_pkg::csum_fold(r_b_tcp_sum);
        end
    end

endmodule

`default_nettype wire

@@ rtl/tcp_reply_header_generator.sv @@
// TCP reply header generator: three-stage pipeline, one beat per cycle while
// m_axis_tready is high. An accepted beat passes through the state register,
// word-sum register and fold/output register to o-side tvalid. Stages hold
// independently, so two more beats are taken while a result waits.
// Reset (synchronous, active low) zeroes the connection state and IP id,
// empties the pipeline and returns the registers to their defaults.
`default_nettype none

module tcp_reply_header_generator (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [4:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    // [5:0] rx_flags, [37:6] rx_seq, [69:38] rx_ack, [80:70] payload_len,
    // [112:81] initial_seq, [119:113] zero
    input  wire logic [119:0]   s_axis_tdata,
    // [0] operation
    input  wire logic           s_axis_tuser,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // [31:0] tx_seq_out, [63:32] tx_ack_out, [69:64] tx_flags_out,
    // [85:70] ip_id_out, [101:86] ip_checksum, [117:102] tcp_checksum,
    // [119:118] zero
    output logic [119:0]        m_axis_tdata,
    // [0] recognized
    output logic                m_axis_tuser
);

    tcprg_pkg::t_cfg    w_cfg;
    tcprg_pkg::t_hdr    w_hdr;
    tcprg_pkg::t_result w_result;
    logic               w_a_valid;
    logic               w_a_take;

    tcprg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tcprg_state u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_op          (s_axis_tuser),
        .i_rx_flags    (s_axis_tdata[5:0]),
        .i_rx_seq      (s_axis_tdata[37:6]),
        .i_rx_ack      (s_axis_tdata[69:38]),
        .i_payload_len (s_axis_tdata[80:70]),
        .i_initial_seq (s_axis_tdata[112:81]),
        .i_take        (w_a_take),
        .o_valid       (w_a_valid),
        .o_hdr         (w_hdr)
    );

    tcprg_csum u_csum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_a_valid),
        .o_take   (w_a_take),
        .i_hdr    (w_hdr),
        .i_cfg    (w_cfg),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = {2'b00,
                           w_result.tcp_checksum,
                           w_result.ip_checksum,
                           w_result.hdr.ip_id,
                           w_result.hdr.flags,
                           w_result.hdr.ack,
                           w_result.hdr.seq};
    assign m_axis_tuser = w_result.hdr.ok;

endmodule

`default_nettype wire
